// ===== sv/odrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// odrgb_pkg
// shared types, bayer threshold table and offset helpers for the dither block
// ----------------------------------------------------------------------------
package odrgb_pkg;

  // signed channel offset, range -127..111
  typedef logic signed [7:0] off_t;

  // pixel as held in the input register, only the low position bits kept
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] col;
    logic [1:0] row;
  } pix_t;

  // 4x4 bayer threshold at (row, col)
  function automatic logic [3:0] bayer_thr(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] t;
    case ({row, col})
      4'h0:    t = 4'd0;
      4'h1:    t = 4'd8;
      4'h2:    t = 4'd2;
      4'h3:    t = 4'd10;
      4'h4:    t = 4'd12;
      4'h5:    t = 4'd4;
      4'h6:    t = 4'd14;
      4'h7:    t = 4'd6;
      4'h8:    t = 4'd3;
      4'h9:    t = 4'd11;
      4'ha:    t = 4'd1;
      4'hb:    t = 4'd9;
      4'hc:    t = 4'd15;
      4'hd:    t = 4'd7;
      4'he:    t = 4'd13;
      4'hf:    t = 4'd5;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  // divide by 16, truncating toward zero
  function automatic off_t div16_tz(input logic signed [12:0] p);
    logic signed [12:0] a;
    a = p[12] ? (p + 13'sd15) : p;
    return off_t'(a[11:4]);
  endfunction

  // (t-8)*k/16 for the given scale k
  function automatic off_t thr_off(input logic [3:0] t, input logic [12:0] k);
    logic signed [4:0]  d;
    logic signed [12:0] p;
    d = $signed({1'b0, t}) - 5'sd8;
    p = $signed({{8{d[4]}}, d} * k);
    return div16_tz(p);
  endfunction

  localparam logic [12:0] SMALL_SCALE = 13'd85;
  localparam logic [12:0] LARGE_SCALE = 13'd255;

endpackage

// ===== sv/odrgb_chan.sv =====
// ----------------------------------------------------------------------------
// odrgb_chan
// one color channel: add dither offset, saturate, quantize to 2 or 4 levels
// ----------------------------------------------------------------------------
module odrgb_chan
  import odrgb_pkg::*;
(
  input  logic [7:0] pixel,
  input  off_t       small_off,
  input  off_t       large_off,
  input  logic       two_level,
  output logic [1:0] level
);

  off_t              off;
  logic signed [9:0] sum;
  logic [7:0]        sat;
  logic [9:0]        scaled;

  always_comb begin
    off = two_level ? large_off : small_off;
    sum = $signed({2'b00, pixel}) + 10'(off);
    if (sum < 10'sd0) begin
      sat = 8'd0;
    end else if (sum > 10'sd255) begin
      sat = 8'd255;
    end else begin
      sat = sum[7:0];
    end
    // (v*3 + 127) / 255 as three compares
    scaled = ({2'b00, sat} * 10'd3) + 10'd127;
    if (two_level) begin
      // (v + 127) / 255
      level = {1'b0, sat[7]};
    end else if (scaled >= 10'd765) begin
      level = 2'd3;
    end else if (scaled >= 10'd510) begin
      level = 2'd2;
    end else if (scaled >= 10'd255) begin
      level = 2'd1;
    end else begin
      level = 2'd0;
    end
  end

endmodule

// ===== sv/odrgb_dither.sv =====
// ----------------------------------------------------------------------------
// odrgb_dither
// threshold lookup, offsets and per-channel quantizers, packs the index
// ----------------------------------------------------------------------------
module odrgb_dither
  import odrgb_pkg::*;
(
  input  pix_t       pix,
  input  logic       cube_mode,
  output logic [4:0] palette_index
);

  logic [3:0] thr;
  off_t       small_off;
  off_t       large_off;
  logic [1:0] r_lvl;
  logic [1:0] g_lvl;
  logic [1:0] b_lvl;

  always_comb begin
    thr       = bayer_thr(pix.row, pix.col);
    small_off = thr_off(thr, SMALL_SCALE);
    large_off = thr_off(thr, LARGE_SCALE);
  end

  odrgb_chan u_red (
    .pixel     (pix.red),
    .small_off (small_off),
    .large_off (large_off),
    .two_level (cube_mode),
    .level     (r_lvl)
  );

  odrgb_chan u_green (
    .pixel     (pix.green),
    .small_off (small_off),
    .large_off (large_off),
    .two_level (1'b0),
    .level     (g_lvl)
  );

  odrgb_chan u_blue (
    .pixel     (pix.blue),
    .small_off (small_off),
    .large_off (large_off),
    .two_level (1'b1),
    .level     (b_lvl)
  );

  // red*8 + green*2 + blue, fields do not overlap
  assign palette_index = {r_lvl, g_lvl, b_lvl[0]};

endmodule

// ===== sv/ordered_dither_rgb_to_index.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_rgb_to_index
// 4x4 bayer ordered dither of an rgb pixel into a 32 or 16 entry palette index
// ----------------------------------------------------------------------------
//  channel | ports                                   | request moves
//  --------+-----------------------------------------+---------------------------
//  in      | in_valid/in_ready, in_red..in_line      | one pixel with position
//  out     | out_valid/out_ready, out_palette_index  | one palette index
//  cfg     | cfg_we, cfg_wdata                       | cube_mode write, no wait
//
//  one request per cycle sustained while out_ready stays high; an accepted
//  request passes the input register and then the result register before out_valid
//  shows it; input register -> dither logic -> result register, both stages advance
//  whenever the stage ahead is empty or being drained
//  rst_n (synchronous) clears both stage valids and sets cube_mode to 0
//  a stall on out_ready holds the result; in_ready drops only when both
//  stages are full and the result is not taken
// ----------------------------------------------------------------------------
module ordered_dither_rgb_to_index
  import odrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [11:0] in_column,
  input  logic [11:0] in_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_palette_index,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  // configuration
  logic cube_mode_r;

  // stage 1: input register
  logic s1_valid_r;
  pix_t s1_pix_r;

  // stage 2: result register
  logic       s2_valid_r;
  logic [4:0] s2_index_r;
  logic [4:0] s2_index_nxt;

  logic s2_ready;
  logic in_take;
  logic s1_move;

  // a stage can load when it is empty or its content leaves this cycle
  assign s2_ready = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign in_take  = in_valid && in_ready;
  assign s1_move  = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_mode_r <= 1'b0;
    end else if (cfg_we) begin
      cube_mode_r <= cfg_wdata;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // stage 1 payload, only the low position bits select the threshold
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r.red   <= in_red;
      s1_pix_r.green <= in_green;
      s1_pix_r.blue  <= in_blue;
      s1_pix_r.col   <= in_column[1:0];
      s1_pix_r.row   <= in_line[1:0];
    end
  end

  // dither and quantize between the two registers
  odrgb_dither u_dither (
    .pix           (s1_pix_r),
    .cube_mode     (cube_mode_r),
    .palette_index (s2_index_nxt)
  );

  // stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_index_r <= s2_index_nxt;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_palette_index = s2_index_r;

  // an accepted request always lands in stage 1
  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted request not held in input stage");

  // a request in stage 1 moves to the result when the result can load
  a_s1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> s2_valid_r)
    else $error("input stage did not advance to result stage");

  // full pipeline with a stalled result must push back on the input
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline full");

  // after reset both stages are empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !s2_valid_r)
    else $error("pipeline not empty after reset");

endmodule
